/* rtl/core/cdq_pkg.sv */
// Shared types and constants for the circular deque.
// Used by cdq_cell and circular_deque; no dependencies.
package cdq_pkg;

   localparam int DEPTH      = 8;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT,
      CELL_LOAD
   } cell_op_type;

   typedef logic [DATA_WIDTH-1:0] word_type;

   function automatic word_type to_word(logic [31:0] v);
      logic [63:0] t;
      t = 64'(v);
      return t[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] to_out(word_type w);
      logic [63:0] t;
      t = 64'(w);
      return t[31:0];
   endfunction

endpackage

/* rtl/core/cdq_cell.sv */
// One deque slot: holds a word and takes it from a neighbor or the request.
// Depends on cdq_pkg.
module cdq_cell
   import cdq_pkg::*;
(
   input  logic        clock,
   input  cell_op_type op,
   input  word_type    prev_data,
   input  word_type    next_data,
   input  word_type    load_data,
   output word_type    data_out
);

   word_type data_ff;
   word_type data_in;

   always_comb begin
      unique case (op)
         CELL_HOLD:      data_in = data_ff;
         CELL_FROM_PREV: data_in = prev_data;
         CELL_FROM_NEXT: data_in = next_data;
         CELL_LOAD:      data_in = load_data;
         default:        data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

/* rtl/core/circular_deque.sv */
// Circular deque top level: a row of cdq_cell slots, front entry in cell 0.
// Depends on cdq_pkg and cdq_cell.
// A request's response is registered and is valid in the cycle after acceptance.
// Throughput: one request per cycle unless a response stalls; cells shift or load on accept.
// Reset clears the entry count and the response valid; cell contents are not cleared.
module circular_deque
   import cdq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_value_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic               rsp_is_empty,
   output logic               rsp_is_full
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [31:0]      value_ff, value_in;
   logic             empty_ff, full_ff;

   cell_op_type      cell_op [DEPTH];
   word_type         cell_data [DEPTH];
   word_type         push_word;
   word_type         rear_word;
   logic [CNT_W-1:0] rear_idx;
   logic             accept;
   logic             is_empty, is_full;

   assign push_word = to_word(req_value_in);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign rear_idx  = count_ff - CNT_W'(1);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type prev_d, next_d;
      if (i == 0) begin : g_first
         assign prev_d = push_word;
      end else begin : g_mid
         assign prev_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_d = cell_data[i];
      end else begin : g_inner
         assign next_d = cell_data[i+1];
      end
      cdq_cell u_cell (
         .clock     (clock),
         .op        (cell_op[i]),
         .prev_data (prev_d),
         .next_data (next_d),
         .load_data (push_word),
         .data_out  (cell_data[i])
      );
   end

   always_comb begin
      rear_word = cell_data[0];
      for (int i = 0; i < DEPTH; i++) begin
         if (CNT_W'(i) == rear_idx) rear_word = cell_data[i];
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_HOLD;
      count_in     = count_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         value_in     = '0;
         unique case (req_opcode)
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_FROM_PREV;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_PUSH_REAR: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CNT_W'(i) == count_ff) cell_op[i] = CELL_LOAD;
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  value_in = to_out(cell_data[0]);
                  if (req_opcode == OP_POP_FRONT) begin
                     for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_FROM_NEXT;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            OP_POP_REAR, OP_PEEK_REAR: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  value_in = to_out(rear_word);
                  if (req_opcode == OP_POP_REAR) count_in = count_ff - CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      if (accept) begin
         empty_ff <= (count_in == '0);
         full_ff  <= (count_in == CNT_W'(DEPTH));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_value_out = value_ff;
   assign rsp_is_empty  = empty_ff;
   assign rsp_is_full   = full_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == OP_PUSH_FRONT || req_opcode == OP_PUSH_REAR) && !is_full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow count");

   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request gave no response");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_is_full)
      else $error("full status without full flag");

endmodule
